FILE: rtl/last_note_priority_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// Last note priority tracker - assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LAST_NOTE_PRIORITY_TRACKER_TOP_DEFINES_SVH
`define LAST_NOTE_PRIORITY_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTH
`define LNPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LNPT_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define LNPT_ASSERT(lbl, prop, msg)
`define LNPT_ASSERT_IMP(lbl, pre, post, msg)
`endif

`endif

FILE: rtl/lnpt_pkg.sv
// ----------------------------------------------------------------------------
// Last note priority tracker - package
// Shared constants, state and cell control types.
// ----------------------------------------------------------------------------
package lnpt_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int NOTE_W          = 7;
    localparam int IDX_W           = 7;
    localparam int GROUP_SIZE      = 8;
    localparam int GROUP_IDX_W     = 3;

    localparam logic [NOTE_W-1:0] KEY_CENTER = 7'd69;

    localparam logic CMD_NOTE_ON  = 1'b0;
    localparam logic CMD_NOTE_OFF = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_INDEX,
        S_APPLY
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_UP,
        CELL_DOWN
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] lim;
    } t_cell_ctl;

endpackage

FILE: rtl/lnpt_cell.sv
// ----------------------------------------------------------------------------
// Last note priority tracker - stack cell
// Holds one stack entry (newest at position zero), compares it against the
// request note and moves it to or from its neighbors.
// ----------------------------------------------------------------------------
module lnpt_cell import lnpt_pkg::*; #(
    parameter int POS   = 0,
    parameter int CNT_W = 8
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [NOTE_W-1:0] i_cmp_note,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [NOTE_W-1:0] i_lower,
    input  logic [NOTE_W-1:0] i_upper,
    output logic [NOTE_W-1:0] o_note,
    output logic [NOTE_W-1:0] o_next,
    output logic              o_match
);

    logic [NOTE_W-1:0] r_note;
    logic [NOTE_W-1:0] n_note;

    always_comb begin
        n_note = r_note;
        unique case (i_ctl.op)
            CELL_UP: begin
                if (IDX_W'(POS) <= i_ctl.lim) n_note = i_lower;
            end
            CELL_DOWN: begin
                if (IDX_W'(POS) >= i_ctl.lim) n_note = i_upper;
            end
            default: n_note = r_note;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_note <= n_note;
    end

    assign o_note  = r_note;
    assign o_next  = n_note;
    assign o_match = (CNT_W'(POS) < i_count) && (r_note == i_cmp_note);

endmodule

FILE: rtl/lnpt_enc.sv
// ----------------------------------------------------------------------------
// Last note priority tracker - match encoder
// Two-stage registered OR tree turning the one-hot match row into an index.
// ----------------------------------------------------------------------------
module lnpt_enc import lnpt_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic [STACK_DEPTH-1:0] i_match,
    output logic                   o_found,
    output logic [IDX_W-1:0]       o_idx
);

    localparam int NG   = (STACK_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PADW = NG * GROUP_SIZE;

    logic [PADW-1:0]        w_pad;
    logic [NG-1:0]          n_any;
    logic [GROUP_IDX_W-1:0] n_low [NG];
    logic [NG-1:0]          r_any;
    logic [GROUP_IDX_W-1:0] r_low [NG];
    logic                   n_found;
    logic [IDX_W-1:0]       n_idx;
    logic                   r_found;
    logic [IDX_W-1:0]       r_idx;

    assign w_pad = PADW'(i_match);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_any[g] = |w_pad[g*GROUP_SIZE +: GROUP_SIZE];
            n_low[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (w_pad[g*GROUP_SIZE + j]) n_low[g] = n_low[g] | GROUP_IDX_W'(j);
            end
        end
    end

    always_comb begin
        n_found = |r_any;
        n_idx   = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_any[g]) begin
                n_idx = n_idx | IDX_W'(g * GROUP_SIZE) | IDX_W'(r_low[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_any   <= n_any;
        r_low   <= n_low;
        r_found <= n_found;
        r_idx   <= n_idx;
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;

endmodule

FILE: rtl/last_note_priority_tracker_top.sv
// A request passes through the accept, group, index and apply steps before its result is valid.
// A new request is taken only once the previous one is applied, after the match, two-level
// encode and cell update steps; apply waits while the previous result is still untaken.
// Reset: synchronous active low; clears held count, sets last note to 69,
// stack cells are not cleared.
// ----------------------------------------------------------------------------
// Last note priority tracker - top level
// Chain of stack cells tracking held notes with last-note priority.
// ----------------------------------------------------------------------------
`include "last_note_priority_tracker_top_defines.svh"

module last_note_priority_tracker_top import lnpt_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [6:0] note
    input  logic        i_s_tuser,   // [0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [6:0] last_note, [14:7] held_count,
                                     // [22:15] note_offset
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    t_state                 r_state, n_state;
    logic                   r_cmd;
    logic [NOTE_W-1:0]      r_note;
    logic [STACK_DEPTH-1:0] r_match;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [NOTE_W-1:0]      r_prio, n_prio;
    logic                   r_out_valid;
    logic [NOTE_W-1:0]      r_out_last;
    logic [7:0]             r_out_count;
    logic [7:0]             r_out_off;

    logic [NOTE_W-1:0]      w_note  [STACK_DEPTH];
    logic [NOTE_W-1:0]      w_next  [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] w_match;
    logic                   w_found;
    logic [IDX_W-1:0]       w_idx;
    t_cell_ctl              w_ctl;
    logic                   w_accept;
    logic                   w_apply;
    logic                   w_push_ok;
    logic                   w_out_free;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_push_ok  = w_found || (r_count < CNT_W'(STACK_DEPTH));

    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        logic [NOTE_W-1:0] w_lower;
        logic [NOTE_W-1:0] w_upper;
        if (k == 0) begin : g_first
            assign w_lower = r_note;
        end else begin : g_mid_lo
            assign w_lower = w_note[k-1];
        end
        if (k == STACK_DEPTH - 1) begin : g_last
            assign w_upper = w_note[k];
        end else begin : g_mid_hi
            assign w_upper = w_note[k+1];
        end
        lnpt_cell #(
            .POS   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_cmp_note (i_s_tdata[NOTE_W-1:0]),
            .i_count    (r_count),
            .i_lower    (w_lower),
            .i_upper    (w_upper),
            .o_note     (w_note[k]),
            .o_next     (w_next[k]),
            .o_match    (w_match[k])
        );
    end

    lnpt_enc #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_enc (
        .i_clk   (i_clk),
        .i_match (r_match),
        .o_found (w_found),
        .o_idx   (w_idx)
    );

    always_comb begin
        n_state   = r_state;
        w_apply   = 1'b0;
        w_ctl.op  = CELL_HOLD;
        w_ctl.lim = w_idx;
        n_count   = r_count;
        n_prio    = r_prio;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_GROUP;
            end
            S_GROUP: n_state = S_INDEX;
            S_INDEX: n_state = S_APPLY;
            S_APPLY: begin
                if (w_out_free) begin
                    w_apply = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd == CMD_NOTE_ON) begin
                        if (w_push_ok) w_ctl.op = CELL_UP;
                        if (!w_found) w_ctl.lim = IDX_W'(STACK_DEPTH - 1);
                        if (!w_found && w_push_ok) n_count = r_count + CNT_W'(1);
                        n_prio = r_note;
                    end else begin
                        if (w_found) begin
                            w_ctl.op = CELL_DOWN;
                            n_count  = r_count - CNT_W'(1);
                        end
                        if (n_count != '0) n_prio = w_next[0];
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_prio      <= KEY_CENTER;
            r_out_valid <= 1'b0;
            r_match     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_prio  <= n_prio;
            if (w_accept) r_match <= w_match;
            if (w_apply) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_s_tuser;
            r_note <= i_s_tdata[NOTE_W-1:0];
        end
        if (w_apply) begin
            r_out_last  <= n_prio;
            r_out_count <= 8'(n_count);
            r_out_off   <= {1'b0, n_prio} - {1'b0, KEY_CENTER};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_off, r_out_count, r_out_last};

    `LNPT_ASSERT(a_count_bound, (r_count <= CNT_W'(STACK_DEPTH)), "held count above depth")
    `LNPT_ASSERT(a_match_unique, $onehot0(r_match), "note held more than once")
    `LNPT_ASSERT_IMP(a_out_apply, $rose(r_out_valid), $past(r_state == S_APPLY), "stray result")

endmodule

FILE: tb/last_note_priority_tracker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Last note priority tracker - stream testbench
// Drives note-on and note-off requests with random gaps and back-pressure,
// models the held-note stack alongside the block, and checks every result
// field against the modeled last note, held count and keytrack offset.
// ----------------------------------------------------------------------------
module last_note_priority_tracker_top_test;
    import lnpt_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct packed {
        logic [6:0] last_note;
        logic [7:0] held_count;
        logic [7:0] note_offset;
    } t_note_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;   // [6:0] note
    logic        i_s_tuser  = CMD_NOTE_ON;   // [0] command
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;   // [6:0] last_note, [14:7] held_count, [22:15] note_offset

    logic [6:0]   held_notes[$];
    logic [6:0]   priority_note = KEY_CENTER;
    t_note_result pending_results[$];

    int error_count     = 0;
    int results_checked = 0;
    int events_sent     = 0;
    int max_held        = 0;
    int input_stalls    = 0;
    int rx_hold_request = 0;
    int rx_hold_left    = 0;
    bit idle_on         = 1'b1;

    last_note_priority_tracker_top #(
        .STACK_DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    function automatic t_note_result apply_note_event(logic cmd, logic [6:0] note);
        t_note_result res;
        int           pos;
        pos = -1;
        for (int k = 0; k < held_notes.size(); k++) begin
            if (pos < 0 && held_notes[k] == note) begin
                pos = k;
            end
        end
        if (pos >= 0) begin
            held_notes.delete(pos);
        end
        if (cmd == CMD_NOTE_ON) begin
            if (held_notes.size() < DEPTH) begin
                held_notes.push_back(note);
            end
            priority_note = note;
        end else if (held_notes.size() > 0) begin
            priority_note = held_notes[held_notes.size() - 1];
        end
        res.last_note   = priority_note;
        res.held_count  = 8'(held_notes.size());
        res.note_offset = {1'b0, priority_note} - {1'b0, KEY_CENTER};
        return res;
    endfunction

    task automatic send_note_event(logic cmd, logic [6:0] note);
        if (idle_on && $urandom_range(0, 99) < 37) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {1'b0, note};
        @(posedge i_clk);
        while (!o_s_tready) begin
            input_stalls++;
            @(posedge i_clk);
        end
        pending_results.push_back(apply_note_event(cmd, note));
        events_sent++;
        if (held_notes.size() > max_held) begin
            max_held = held_notes.size();
        end
    endtask

    task automatic wait_for_results();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (12) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
            pending_results.delete();
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold_request > 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0) begin
            i_m_tready <= 1'b0;
            rx_hold_left--;
        end else if (idle_on && $urandom_range(0, 99) < 37) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_note_result exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: tdata %h", o_m_tdata);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (o_m_tdata[6:0] !== exp_res.last_note) begin
                    $error("last_note mismatch: expected %0d, got %0d",
                           exp_res.last_note, o_m_tdata[6:0]);
                    error_count++;
                end
                if (o_m_tdata[14:7] !== exp_res.held_count) begin
                    $error("held_count mismatch: expected %0d, got %0d",
                           exp_res.held_count, o_m_tdata[14:7]);
                    error_count++;
                end
                if (o_m_tdata[22:15] !== exp_res.note_offset) begin
                    $error("note_offset mismatch: expected %0d, got %0d",
                           $signed(exp_res.note_offset), $signed(o_m_tdata[22:15]));
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed_events();
        send_note_event(CMD_NOTE_OFF, 7'd5);
        send_note_event(CMD_NOTE_ON,  7'd0);
        send_note_event(CMD_NOTE_ON,  7'd127);
        send_note_event(CMD_NOTE_ON,  7'd0);
        send_note_event(CMD_NOTE_ON,  7'd127);
        send_note_event(CMD_NOTE_OFF, 7'd127);
        send_note_event(CMD_NOTE_OFF, 7'd99);
        send_note_event(CMD_NOTE_ON,  KEY_CENTER);
        send_note_event(CMD_NOTE_ON,  7'h55);
        send_note_event(CMD_NOTE_ON,  7'h2A);
        send_note_event(CMD_NOTE_ON,  KEY_CENTER);
        send_note_event(CMD_NOTE_OFF, 7'h2A);
        send_note_event(CMD_NOTE_OFF, KEY_CENTER);
        send_note_event(CMD_NOTE_OFF, 7'h55);
        send_note_event(CMD_NOTE_OFF, 7'd0);
        send_note_event(CMD_NOTE_OFF, 7'd0);
        send_note_event(CMD_NOTE_ON,  7'd127);
        send_note_event(CMD_NOTE_OFF, 7'd127);
        send_note_event(CMD_NOTE_OFF, 7'd64);
        wait_for_results();
    endtask

    task automatic test_full_stack();
        logic [6:0] order[DEPTH];
        logic [6:0] tmp;
        int         j;
        for (int i = 0; i < DEPTH; i++) begin
            order[i] = 7'(i);
        end
        for (int i = DEPTH - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < DEPTH; i++) begin
            send_note_event(CMD_NOTE_ON, order[i]);
        end
        send_note_event(CMD_NOTE_ON, order[0]);
        send_note_event(CMD_NOTE_ON, order[DEPTH/2]);
        send_note_event(CMD_NOTE_ON, order[DEPTH-1]);
        for (int i = DEPTH - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < DEPTH; i++) begin
            send_note_event(CMD_NOTE_OFF, order[i]);
        end
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        bit saved_idle;
        saved_idle      = idle_on;
        idle_on         = 1'b0;
        rx_hold_request = 64;
        for (int i = 0; i < 30; i++) begin
            send_note_event(i % 5 == 4 ? CMD_NOTE_OFF : CMD_NOTE_ON,
                            7'($urandom_range(0, 127)));
        end
        idle_on = saved_idle;
        wait_for_results();
    endtask

    task automatic test_random_events(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            if (i == count / 3) begin
                idle_on = 1'b0;
            end
            if (i == 2 * count / 3) begin
                idle_on = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (held_notes.size() > 0 && r < 40) begin
                send_note_event(CMD_NOTE_OFF,
                                held_notes[$urandom_range(0, held_notes.size() - 1)]);
            end else if (r < 50) begin
                send_note_event(CMD_NOTE_OFF, 7'($urandom_range(0, 127)));
            end else if (held_notes.size() > 0 && r < 60) begin
                send_note_event(CMD_NOTE_ON,
                                held_notes[$urandom_range(0, held_notes.size() - 1)]);
            end else if ($urandom_range(0, 3) == 0) begin
                send_note_event(CMD_NOTE_ON, 7'($urandom_range(0, 127)));
            end else begin
                send_note_event(CMD_NOTE_ON, 7'($urandom_range(48, 84)));
            end
        end
        wait_for_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_events();
        test_full_stack();
        test_output_backpressure();
        test_random_events(200);
        $display("Covered %0d note events, %0d results checked, held count up to %0d,",
                 events_sent, results_checked, max_held);
        $display("with %0d request cycles spent waiting for the input to be ready.",
                 input_stalls);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lnpt_pkg.sv
rtl/lnpt_cell.sv
rtl/lnpt_enc.sv
rtl/last_note_priority_tracker_top.sv
tb/last_note_priority_tracker_top_test.sv
